>>> design/background_tile_pixel_fetcher_assert.svh
// Assertion macros used by the background tile fetcher top level.
`ifndef BACKGROUND_TILE_PIXEL_FETCHER_ASSERT_SVH
`define BACKGROUND_TILE_PIXEL_FETCHER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define BTPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("btpf: same-cycle check failed");

// Next-cycle implication, clocked on clk_i and disabled while rst_ni is low.
`define BTPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("btpf: next-cycle check failed");

`endif

>>> design/btpf_pkg.sv
// Types and constants of the background tile pixel fetcher.
package btpf_pkg;

  // Item modes.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_POP   = 2'd2;

  // Fetch phases.
  localparam logic [1:0] PH_TILE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_PUSH = 2'd3;

  // Tile data areas.
  localparam logic [15:0] AREA_UNSIGNED = 16'h8000;
  localparam logic [15:0] AREA_SIGNED   = 16'h9000;

  localparam int unsigned LEVEL_W    = 5;
  localparam int unsigned ROW_PIXELS = 8;
  localparam int unsigned ROW_W      = 16;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  vram_byte;
    logic [15:0] map_base;
    logic [7:0]  line_in_tile;
  } in_t;

  typedef struct packed {
    logic [1:0]  pixel;
    logic        pixel_valid;
    logic [4:0]  fifo_level;
    logic [15:0] read_address;
    logic [1:0]  fetch_phase;
  } out_t;

  // Fetch control for one accepted word.
  typedef struct packed {
    logic        tick;
    logic        start;
    logic [7:0]  data;
    logic [15:0] map_base;
    logic [7:0]  line;
  } fetch_ctl_t;

  // FIFO commands for one accepted word.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } fifo_ctl_t;

  // FIFO status seen by the fetcher and the output pipeline.
  typedef struct packed {
    logic [LEVEL_W-1:0] count;
    logic               can_push;
    logic               nonempty;
    logic [2:0]         head_off;
  } fifo_stat_t;

endpackage

>>> design/btpf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module btpf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next enabled read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/btpf_fifo.sv
// Pixel FIFO: rows of eight pixels in a RAM, with head, tail and count.
module btpf_fifo #(
  parameter int unsigned FIFO_DEPTH = 16,
  parameter int unsigned PUSH_LIMIT = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  btpf_pkg::fifo_ctl_t                 ctl_i,
  input  logic [btpf_pkg::ROW_W-1:0]          push_word_i,
  output btpf_pkg::fifo_stat_t                stat_o,
  output logic [btpf_pkg::ROW_W-1:0]          row_o
);

  localparam int unsigned ROWS = FIFO_DEPTH / btpf_pkg::ROW_PIXELS;
  localparam int unsigned RW   = $clog2(ROWS);

  logic [RW-1:0]                  tail_row_q, tail_row_d;
  logic [RW-1:0]                  head_row_q, head_row_d;
  logic [2:0]                     head_off_q, head_off_d;
  logic [btpf_pkg::LEVEL_W-1:0]   count_q, count_d;
  logic                           can_push;
  logic                           do_push;
  logic                           do_pop;

  // A push needs the level at or below the limit and room for a whole row.
  assign can_push = (count_q <= btpf_pkg::LEVEL_W'(PUSH_LIMIT)) &&
                    (({1'b0, count_q} + 6'd8) <= 6'(FIFO_DEPTH));
  assign do_push  = ctl_i.push && can_push;
  assign do_pop   = ctl_i.pop && (count_q != '0);

  // Pointer and level update.
  always_comb begin
    tail_row_d = tail_row_q;
    head_row_d = head_row_q;
    head_off_d = head_off_q;
    count_d    = count_q;
    if (ctl_i.clear) begin
      tail_row_d = '0;
      head_row_d = '0;
      head_off_d = '0;
      count_d    = '0;
    end else if (do_push) begin
      tail_row_d = (tail_row_q == RW'(ROWS - 1)) ? '0 : tail_row_q + 1'b1;
      count_d    = count_q + btpf_pkg::LEVEL_W'(btpf_pkg::ROW_PIXELS);
    end else if (do_pop) begin
      head_off_d = head_off_q + 1'b1;
      count_d    = count_q - 1'b1;
      if (head_off_q == 3'd7) begin
        head_row_d = (head_row_q == RW'(ROWS - 1)) ? '0 : head_row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_row_q <= '0;
      head_row_q <= '0;
      head_off_q <= '0;
      count_q    <= '0;
    end else begin
      tail_row_q <= tail_row_d;
      head_row_q <= head_row_d;
      head_off_q <= head_off_d;
      count_q    <= count_d;
    end
  end

  // Pixel rows; a pop reads the head row at its accept edge.
  btpf_ram #(
    .WIDTH (btpf_pkg::ROW_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (tail_row_q),
    .wdata_i (push_word_i),
    .re_i    (ctl_i.pop),
    .raddr_i (head_row_q),
    .rdata_o (row_o)
  );

  assign stat_o.count    = count_q;
  assign stat_o.can_push = can_push;
  assign stat_o.nonempty = (count_q != '0);
  assign stat_o.head_off = head_off_q;

endmodule

>>> design/btpf_fetch.sv
// Fetch sequencer: tick parity, phase, tile registers and read address.
module btpf_fetch (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  btpf_pkg::fetch_ctl_t       ctl_i,
  input  logic                       unsigned_area_i,
  input  logic                       can_push_i,
  output logic                       push_o,
  output logic [btpf_pkg::ROW_W-1:0] push_word_o,
  output logic [1:0]                 phase_o,
  output logic [15:0]                addr_o
);

  logic        tick_half_q, tick_half_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  tile_cnt_q, tile_cnt_d;
  logic [15:0] row_base_q, row_base_d;
  logic [7:0]  row_in_tile_q, row_in_tile_d;
  logic [7:0]  tile_num_q, tile_num_d;
  logic [7:0]  lo_q, lo_d;
  logic [7:0]  hi_q, hi_d;
  logic        act;
  logic [15:0] tile_base;
  logic [15:0] plane_addr;

  // Only every second tick does fetch work.
  assign act    = ctl_i.tick && tick_half_q;
  assign push_o = act && (phase_q == btpf_pkg::PH_PUSH);

  always_comb begin
    tick_half_d   = tick_half_q;
    phase_d       = phase_q;
    tile_cnt_d    = tile_cnt_q;
    row_base_d    = row_base_q;
    row_in_tile_d = row_in_tile_q;
    tile_num_d    = tile_num_q;
    lo_d          = lo_q;
    hi_d          = hi_q;
    if (ctl_i.tick) begin
      tick_half_d = !tick_half_q;
    end
    if (ctl_i.start) begin
      row_base_d    = ctl_i.map_base;
      row_in_tile_d = ctl_i.line;
      tile_cnt_d    = '0;
      phase_d       = btpf_pkg::PH_TILE;
    end else if (act) begin
      case (phase_q)
        btpf_pkg::PH_TILE: begin
          tile_num_d = ctl_i.data;
          lo_d       = '0;
          hi_d       = '0;
          phase_d    = btpf_pkg::PH_LOW;
        end
        btpf_pkg::PH_LOW: begin
          lo_d    = ctl_i.data;
          hi_d    = '0;
          phase_d = btpf_pkg::PH_HIGH;
        end
        btpf_pkg::PH_HIGH: begin
          hi_d    = ctl_i.data;
          phase_d = btpf_pkg::PH_PUSH;
        end
        default: begin
          if (can_push_i) begin
            tile_cnt_d = tile_cnt_q + 1'b1;
            phase_d    = btpf_pkg::PH_TILE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_half_q   <= 1'b0;
      phase_q       <= btpf_pkg::PH_TILE;
      tile_cnt_q    <= '0;
      row_base_q    <= '0;
      row_in_tile_q <= '0;
      tile_num_q    <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
    end else begin
      tick_half_q   <= tick_half_d;
      phase_q       <= phase_d;
      tile_cnt_q    <= tile_cnt_d;
      row_base_q    <= row_base_d;
      row_in_tile_q <= row_in_tile_d;
      tile_num_q    <= tile_num_d;
      lo_q          <= lo_d;
      hi_q          <= hi_d;
    end
  end

  // Row word: the most significant pixel sits in the lowest slot.
  always_comb begin
    push_word_o = '0;
    for (int k = 0; k < 8; k++) begin
      push_word_o[2*k +: 2] = {hi_q[7-k], lo_q[7-k]};
    end
  end

  // Tile data base: unsigned from one area, sign-extended tile number from the other.
  assign tile_base  = unsigned_area_i ?
                      (btpf_pkg::AREA_UNSIGNED + {4'b0, tile_num_q, 4'b0}) :
                      (btpf_pkg::AREA_SIGNED + {{4{tile_num_q[7]}}, tile_num_q, 4'b0});
  assign plane_addr = tile_base + {7'b0, row_in_tile_q, 1'b0};

  always_comb begin
    case (phase_q)
      btpf_pkg::PH_TILE: addr_o = row_base_q + {8'b0, tile_cnt_q};
      btpf_pkg::PH_LOW:  addr_o = plane_addr;
      btpf_pkg::PH_HIGH: addr_o = plane_addr + 16'd1;
      default:           addr_o = '0;
    endcase
  end

  assign phase_o = phase_q;

endmodule

>>> design/background_tile_pixel_fetcher.sv
// Top level of the background tile pixel fetcher.
//
// Input channel (in_valid_i/in_ready_o, in_i) takes one word per item: a tick,
// a start of a new row fetch, or a pop of one pixel. Output channel
// (out_valid_o/out_ready_i, out_o) returns exactly one word per input word,
// in order: the popped pixel, the FIFO level, the next read address and the
// fetch phase. The caller presents on each tick the memory byte found at the
// read address of the previous result word.
// An accepted word moves through the middle and result stages; a new word is
// accepted every cycle while in_ready_o is high. The pixel FIFO lives in a RAM
// of eight-pixel rows with a registered read, read at the pop's accept edge and
// picked up in the result stage. cfg_we_i/cfg_wdata_i set the tile area select.
// Reset clears the sequencer, the FIFO pointers and the pipeline, and sets
// the tile area select to the unsigned area; the RAM needs no clearing.
// When the receiver stalls, the result register holds and one more word can
// sit in the middle stage; after that in_ready_o drops until it drains.
module background_tile_pixel_fetcher #(
  parameter int unsigned FIFO_DEPTH = 16,
  parameter int unsigned PUSH_LIMIT = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  btpf_pkg::in_t    in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output btpf_pkg::out_t   out_o,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i
);

  `include "background_tile_pixel_fetcher_assert.svh"

  logic                       utile_q, utile_d;
  logic                       s1_valid_q, s1_valid_d;
  logic                       s1_pop_q, s1_pop_d;
  logic [2:0]                 s1_off_q, s1_off_d;
  logic                       out_valid_q, out_valid_d;
  btpf_pkg::out_t             out_q, out_d;
  logic                       adv;
  logic                       acc;
  btpf_pkg::fetch_ctl_t       fetch_ctl;
  btpf_pkg::fifo_ctl_t        fifo_ctl;
  btpf_pkg::fifo_stat_t       fifo_stat;
  logic                       push;
  logic [btpf_pkg::ROW_W-1:0] push_word;
  logic [btpf_pkg::ROW_W-1:0] row;
  logic [1:0]                 phase;
  logic [15:0]                addr;

  // Handshake: the middle stage moves when the result register is free.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;
  assign acc        = in_valid_i && in_ready_o;

  // Tile area select register.
  assign utile_d = cfg_we_i ? cfg_wdata_i : utile_q;

  // Decode the accepted word.
  assign fetch_ctl.tick     = acc && (in_i.mode == btpf_pkg::MODE_TICK);
  assign fetch_ctl.start    = acc && (in_i.mode == btpf_pkg::MODE_START);
  assign fetch_ctl.data     = in_i.vram_byte;
  assign fetch_ctl.map_base = in_i.map_base;
  assign fetch_ctl.line     = in_i.line_in_tile;

  assign fifo_ctl.push  = push;
  assign fifo_ctl.pop   = acc && (in_i.mode == btpf_pkg::MODE_POP);
  assign fifo_ctl.clear = fetch_ctl.start;

  btpf_fetch u_fetch (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (fetch_ctl),
    .unsigned_area_i (utile_q),
    .can_push_i      (fifo_stat.can_push),
    .push_o          (push),
    .push_word_o     (push_word),
    .phase_o         (phase),
    .addr_o          (addr)
  );

  btpf_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .PUSH_LIMIT (PUSH_LIMIT)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (fifo_ctl),
    .push_word_i (push_word),
    .stat_o      (fifo_stat),
    .row_o       (row)
  );

  // Middle stage: remembers whether a pixel was popped and from which slot.
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_pop_d   = s1_pop_q;
    s1_off_d   = s1_off_q;
    if (acc) begin
      s1_valid_d = 1'b1;
      s1_pop_d   = fifo_ctl.pop && fifo_stat.nonempty;
      s1_off_d   = fifo_stat.head_off;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // Result stage: the state registers reflect the middle-stage word here.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = s1_valid_q;
      if (s1_valid_q) begin
        out_d.pixel        = s1_pop_q ? row[{s1_off_q, 1'b0} +: 2] : 2'd0;
        out_d.pixel_valid  = s1_pop_q;
        out_d.fifo_level   = fifo_stat.count;
        out_d.read_address = addr;
        out_d.fetch_phase  = phase;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utile_q     <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      utile_q     <= utile_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_pop_q <= s1_pop_d;
    s1_off_q <= s1_off_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Checks on the pipeline and the FIFO.
  `BTPF_ASSERT_IMPL(a_ready_blocked, !in_ready_o, s1_valid_q && out_valid_q)
  `BTPF_ASSERT_IMPL(a_level_bound, out_valid_q, out_q.fifo_level <= 5'd16)
  `BTPF_ASSERT_NEXT(a_nopop_zero, adv && s1_valid_q && !s1_pop_q,
                    out_q.pixel == 2'd0 && !out_q.pixel_valid)
  `BTPF_ASSERT_IMPL(a_push_addr, out_valid_q && out_q.fetch_phase == btpf_pkg::PH_PUSH,
                    out_q.read_address == 16'd0)

endmodule
